// File: design/ccp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared constants and types for the 9-bit coefficient compressor and packer.
// ----------------------------------------------------------------------------
package ccp_pkg;

  localparam int POLY_LEN_DEF = 256;

  localparam logic [15:0] KQ     = 16'd3329;
  localparam logic [24:0] KHALF  = 25'd1664;
  localparam logic [20:0] KRECIP = 21'd1290168;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [8:0] val;
    logic       last;
    logic       raw;
  } ccp_entry_t;

endpackage
`default_nettype wire

// File: design/ccp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_front
// Accepts coefficients, quantizes to 9 bits and tags polynomial end and mode.
// ----------------------------------------------------------------------------
module ccp_front
  import ccp_pkg::*;
#(
  parameter int POLY_LEN = POLY_LEN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_coefficient,
  input  wire logic               raw_mode,
  input  wire logic               q_full,
  output logic                    q_push,
  output ccp_entry_t              q_entry
);

  localparam int IDX_W = (POLY_LEN > 1) ? $clog2(POLY_LEN) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POLY_LEN - 1);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      u;
  logic [24:0]      scaled;
  logic [45:0]      prod;
  logic             last;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign last     = (idx_r == IDX_LAST);

  always_comb begin
    u      = in_coefficient[15] ? (in_coefficient + KQ) : in_coefficient;
    scaled = {u, 9'b0} + KHALF;
    prod   = 46'(scaled) * 46'(KRECIP);
    q_entry.val  = prod[40:32];
    q_entry.last = last;
    q_entry.raw  = raw_mode;
    idx_nxt = idx_r;
    if (q_push) begin
      idx_nxt = last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/ccp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_queue
// Short queue of quantized entries between the front and the packer.
// ----------------------------------------------------------------------------
module ccp_queue
  import ccp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire ccp_entry_t  push_entry,
  output logic             full,
  input  wire logic        pop,
  output logic             not_empty,
  output ccp_entry_t       head
);

  ccp_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]       count_r, count_nxt;

  assign full      = (count_r == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: design/ccp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_back
// Bit packer: packs 9-bit values into bytes or sends them raw to the output.
// ----------------------------------------------------------------------------
module ccp_back
  import ccp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_not_empty,
  input  wire ccp_entry_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [8:0]      out_value,
  output logic            out_run_end,
  output logic            out_poly_end
);

  logic [7:0]  bb_r, bb_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [8:0]  out_value_r, out_value_nxt;
  logic        out_run_end_r, out_run_end_nxt;
  logic        out_poly_end_r, out_poly_end_nxt;
  logic        sec_valid_r, sec_valid_nxt;
  logic [8:0]  sec_value_r, sec_value_nxt;
  logic        sec_poly_end_r, sec_poly_end_nxt;

  logic        out_load;
  logic [15:0] buf16;
  logic [4:0]  cntsum;
  logic [8:0]  first_word;
  logic [8:0]  second_word;
  logic        two_words;

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_run_end  = out_run_end_r;
  assign out_poly_end = out_poly_end_r;

  assign out_load = !out_valid_r || out_ready;
  assign q_pop    = q_not_empty && !sec_valid_r && out_load;

  always_comb begin
    buf16  = {8'b0, bb_r} | ({7'b0, q_head.val} << cnt_r);
    cntsum = {2'b0, cnt_r} + 5'd9;
    bb_nxt  = bb_r;
    cnt_nxt = cnt_r;
    second_word = {1'b0, buf16[15:8]};
    if (q_head.raw) begin
      first_word = q_head.val;
      two_words  = 1'b0;
      if (q_head.last) begin
        bb_nxt  = '0;
        cnt_nxt = '0;
      end
    end else begin
      first_word = {1'b0, buf16[7:0]};
      if (cntsum == 5'd16 || q_head.last) begin
        two_words = 1'b1;
        bb_nxt    = '0;
        cnt_nxt   = '0;
      end else begin
        two_words = 1'b0;
        bb_nxt    = buf16[15:8];
        cnt_nxt   = cntsum[2:0];
      end
    end
    if (!q_pop) begin
      bb_nxt  = bb_r;
      cnt_nxt = cnt_r;
    end

    out_valid_nxt    = out_valid_r;
    out_value_nxt    = out_value_r;
    out_run_end_nxt  = out_run_end_r;
    out_poly_end_nxt = out_poly_end_r;
    sec_valid_nxt    = sec_valid_r;
    sec_value_nxt    = sec_value_r;
    sec_poly_end_nxt = sec_poly_end_r;
    if (out_load) begin
      if (sec_valid_r) begin
        out_valid_nxt    = 1'b1;
        out_value_nxt    = sec_value_r;
        out_run_end_nxt  = 1'b1;
        out_poly_end_nxt = sec_poly_end_r;
        sec_valid_nxt    = 1'b0;
      end else if (q_pop) begin
        out_valid_nxt    = 1'b1;
        out_value_nxt    = first_word;
        out_run_end_nxt  = !two_words;
        out_poly_end_nxt = q_head.last && !two_words;
        sec_valid_nxt    = two_words;
        sec_value_nxt    = second_word;
        sec_poly_end_nxt = q_head.last;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bb_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      bb_r        <= bb_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r    <= out_value_nxt;
    out_run_end_r  <= out_run_end_nxt;
    out_poly_end_r <= out_poly_end_nxt;
    sec_value_r    <= sec_value_nxt;
    sec_poly_end_r <= sec_poly_end_nxt;
  end

  a_sec_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid_r |-> out_valid_r)
    else $error("second word pending without an output word");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_run_end_r) |-> sec_valid_r)
    else $error("non-final word without its follow-up");

  a_poly_end_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_poly_end_r) |-> (cnt_r == '0 && out_run_end_r))
    else $error("polynomial end with pending bits");

endmodule
`default_nettype wire

// File: design/coeff_compress9_pack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// coeff_compress9_pack
// 9-bit coefficient compressor with little-endian bit packing.
// ----------------------------------------------------------------------------
// Takes one signed 16-bit coefficient per word, quantizes it to
// round(512*u/q) mod 512 and, in packed mode, emits the stream as bytes
// (eight coefficients give nine bytes) or, in raw mode, the 9-bit value.
// A coefficient is accepted in every cycle while the two-entry queue has
// room and passes the queue, then the output register. Unless out_ready is
// low, one word leaves per cycle: raw mode sustains one coefficient per
// cycle, packed mode eight per nine words, plus one extra word at a
// polynomial end that leaves pending bits. cfg_wdata selects raw mode; the
// user must write it only while the block is idle; no logic enforces this.
// ----------------------------------------------------------------------------
module coeff_compress9_pack
  import ccp_pkg::*;
#(
  parameter int POLY_LEN = POLY_LEN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_coefficient,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [8:0]              out_value,
  output logic                    out_run_end,
  output logic                    out_poly_end
);

  logic       raw_output_r, raw_output_nxt;
  logic       q_full, q_push, q_pop, q_not_empty;
  ccp_entry_t q_in, q_head;

  assign raw_output_nxt = cfg_we ? cfg_wdata : raw_output_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_output_r <= 1'b0;
    end else begin
      raw_output_r <= raw_output_nxt;
    end
  end

  ccp_front #(
    .POLY_LEN(POLY_LEN)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_coefficient (in_coefficient),
    .raw_mode       (raw_output_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_in)
  );

  ccp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  ccp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_run_end  (out_run_end),
    .out_poly_end (out_poly_end)
  );

endmodule
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 9-bit coefficient compressor and byte packer.
// ----------------------------------------------------------------------------
// Coefficients are pushed through the input channel in random bursts while
// the result channel stalls on its own changing pattern. A scoreboard tracks
// the bitstream buffer, pending bit count and polynomial position, and works
// out the bytes (packed mode) or 9-bit values (raw mode) that each accepted
// coefficient should produce. Every word that comes out is checked against
// the oldest expected word. The run covers the field extremes, values around
// the modulus, out-of-range inputs, a mode change with pending bits, a
// polynomial end that flushes a partial byte and one that drops pending bits.
// ----------------------------------------------------------------------------
module tb;

  localparam int          POLY_LEN      = 256;
  localparam int          IDLE_LIMIT    = 2000;
  localparam int          DRAIN_CYCLES  = 4;
  localparam int          RANDOM_TARGET = 600;
  localparam int          MAX_REPORTS   = 10;
  localparam logic [15:0] Q_MOD         = 16'd3329;
  localparam logic [63:0] HALF_Q        = 64'd1664;
  localparam logic [63:0] RECIP         = 64'd1290168;

  typedef enum logic {MODE_PACKED = 1'b0, MODE_RAW = 1'b1} out_mode_t;
  typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_EVERY_THIRD} ready_pattern_t;

  typedef struct packed {
    logic [8:0] value;
    logic       run_end;
    logic       poly_end;
  } word_t;

  class pack_scoreboard;
    out_mode_t   mode;
    logic [15:0] bit_buf;
    logic [3:0]  bit_cnt;
    int unsigned coeff_idx;
    word_t       want_q[$];
    int unsigned mismatches;
    int unsigned words_seen;
    int unsigned coeffs_seen;
    int unsigned poly_ends;
    int unsigned flush_bytes;

    function new();
      mode        = MODE_PACKED;
      bit_buf     = '0;
      bit_cnt     = '0;
      coeff_idx   = 0;
      mismatches  = 0;
      words_seen  = 0;
      coeffs_seen = 0;
      poly_ends   = 0;
      flush_bytes = 0;
    endfunction

    function int unsigned pending();
      return want_q.size();
    endfunction

    function void note_coeff(logic signed [15:0] coeff);
      logic [15:0] u;
      logic [63:0] prod;
      logic [8:0]  q9;
      logic [31:0] acc;
      int unsigned cnt;
      bit          last;
      logic [8:0]  vals[$];
      u = coeff;
      if (u[15]) u = u + Q_MOD;
      prod = ({48'b0, u} << 9) + HALF_Q;
      prod = prod * RECIP;
      q9   = prod[40:32];
      last = (coeff_idx >= POLY_LEN - 1);
      coeffs_seen++;
      if (mode == MODE_RAW) begin
        vals.push_back(q9);
        // pending packed bits are dropped at a polynomial end
        if (last) begin
          bit_buf = '0;
          bit_cnt = '0;
        end
      end else begin
        acc = {24'b0, bit_buf[7:0]} | ({23'b0, q9} << bit_cnt[2:0]);
        cnt = bit_cnt[2:0] + 9;
        while (cnt >= 8) begin
          vals.push_back({1'b0, acc[7:0]});
          acc = acc >> 8;
          cnt = cnt - 8;
        end
        // zero-padded flush of a partial byte
        if (last && cnt > 0) begin
          vals.push_back({1'b0, acc[7:0]});
          flush_bytes++;
          acc = '0;
          cnt = 0;
        end
        bit_buf = acc[15:0];
        bit_cnt = cnt[3:0];
      end
      foreach (vals[k]) begin
        want_q.push_back(word_t'{value: vals[k],
                                 run_end: (k == vals.size() - 1),
                                 poly_end: last && (k == vals.size() - 1)});
      end
      if (last) begin
        coeff_idx = 0;
        poly_ends++;
      end else begin
        coeff_idx++;
      end
    endfunction

    function void check_word(word_t got);
      word_t want;
      words_seen++;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: value=%0d run_end=%0b poly_end=%0b",
                   got.value, got.run_end, got.poly_end);
      end else begin
        want = want_q.pop_front();
        if (got.value !== want.value || got.run_end !== want.run_end ||
            got.poly_end !== want.poly_end) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("word %0d mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     words_seen, want.value, want.run_end, want.poly_end,
                     got.value, got.run_end, got.poly_end);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                cfg_we         = 1'b0;
  logic                cfg_wdata      = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic signed [15:0]  in_coefficient = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [8:0]          out_value;
  logic                out_run_end;
  logic                out_poly_end;

  pack_scoreboard sb = new();
  int unsigned    idle_cycles = 0;
  int unsigned    burst_left  = 0;
  int unsigned    random_sent = 0;
  int unsigned    mode_writes = 0;
  bit             steady      = 1'b0;

  logic signed [15:0] edge_coeffs [15] = '{
    16'sh8000, 16'sh7fff, 16'sd0, -16'sd1, 16'sd1, 16'sd3329, -16'sd3329,
    16'sd3328, -16'sd3328, 16'sd1664, 16'sd1665, -16'sd1664, -16'sd1665,
    16'sd6, 16'sd7
  };
  logic signed [15:0] raw_coeffs [5] = '{
    16'sd3328, -16'sd1, 16'sh7fff, 16'sh8000, 16'sd1665
  };

  coeff_compress9_pack #(
    .POLY_LEN (POLY_LEN)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_coefficient (in_coefficient),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_run_end    (out_run_end),
    .out_poly_end   (out_poly_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // accepted words on both channels, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && in_ready) sb.note_coeff(in_coefficient);
      if (out_valid && out_ready) sb.check_word(word_t'{out_value, out_run_end, out_poly_end});
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern
  initial begin
    ready_pattern_t pat;
    int unsigned    tick;
    tick = 0;
    forever begin
      pat = ready_pattern_t'($urandom_range(0, 3));
      repeat ($urandom_range(16, 96)) begin
        @(negedge clk);
        tick++;
        case (pat)
          RDY_ALWAYS:  out_ready <= 1'b1;
          RDY_MOSTLY:  out_ready <= ($urandom_range(0, 3) != 0);
          RDY_RARELY:  out_ready <= ($urandom_range(0, 3) == 0);
          default:     out_ready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
    $display("tb: errors");
    $finish;
  end

  task automatic send_coeff(input logic signed [15:0] coeff);
    if (!steady && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid       <= 1'b1;
    in_coefficient <= coeff;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  // wait for every expected word, then write the mode register
  task automatic write_mode(input out_mode_t mode);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we  <= 1'b0;
    sb.mode = mode;
    mode_writes++;
  endtask

  task automatic random_phase(input out_mode_t mode, input int unsigned count);
    logic signed [15:0] coeff;
    int unsigned        pick;
    write_mode(mode);
    steady     = ($urandom_range(0, 3) == 0);
    burst_left = 0;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) coeff = 16'($urandom_range(0, 6658)) - 16'd3329;
      else if (pick < 9) coeff = 16'($urandom());
      else coeff = edge_coeffs[$urandom_range(0, 14)];
      send_coeff(coeff);
      random_sent++;
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes and values around q, then a raw run with bits pending
    write_mode(MODE_PACKED);
    foreach (edge_coeffs[i]) send_coeff(edge_coeffs[i]);
    write_mode(MODE_RAW);
    foreach (raw_coeffs[i]) send_coeff(raw_coeffs[i]);

    // first polynomial ends packed and misaligned, the second ends raw
    random_phase(MODE_PACKED, POLY_LEN - 20);
    random_phase(MODE_PACKED, 100);
    random_phase(MODE_RAW, POLY_LEN - 100);
    while (random_sent < RANDOM_TARGET)
      random_phase(out_mode_t'($urandom_range(0, 1)), $urandom_range(1, 80));

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES * 2) @(negedge clk);

    if (sb.pending() != 0) $display("%0d words still expected", sb.pending());
    $display("summary: %0d coefficients in, %0d words out, %0d mismatches",
             sb.coeffs_seen, sb.words_seen, sb.mismatches);
    $display("summary: %0d mode writes, %0d polynomial ends, %0d flush bytes",
             mode_writes, sb.poly_ends, sb.flush_bytes);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: coeff_compress9_pack.f
design/ccp_pkg.sv
design/ccp_front.sv
design/ccp_queue.sv
design/ccp_back.sv
design/coeff_compress9_pack.sv
dv/tb.sv
